>>> rtl/core/palette_shade_bilinear_upscale_macros.svh
// Assertion macros shared by the palette shade upscaler checker.
`ifndef PALETTE_SHADE_BILINEAR_UPSCALE_MACROS_SVH
`define PALETTE_SHADE_BILINEAR_UPSCALE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define PSBU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PSBU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/psbu_pkg.sv
// Shared types, constants and functions of the palette shade upscaler.
`timescale 1ns / 1ps
package psbu_pkg;

  localparam int SRC_WIDTH    = 640;
  localparam int SRC_HEIGHT   = 480;
  localparam int PALETTE_SIZE = 256;
  localparam int FRAME_PIXELS = SRC_WIDTH * SRC_HEIGHT;
  localparam int FRAME_AW     = $clog2(FRAME_PIXELS);
  localparam int PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int XW           = $clog2(SRC_WIDTH);
  localparam int YW           = $clog2(SRC_HEIGHT);
  localparam int SRC_MAX      = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int CW           = (XW > YW) ? XW : YW;
  localparam int PROD_W       = 13 + $clog2(SRC_MAX + 1);
  localparam int DIV_NUM_W    = PROD_W + 15;
  localparam int DIV_CNT_W    = $clog2(DIV_NUM_W + 1);
  localparam int SIZE_W       = 13;
  localparam int F_W          = CW + 16;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int RECIP_100    = 1342177;  // floor(2^27 / 100)
  localparam int RECIP_SH     = 27;
  localparam logic [7:0] ALPHA = 8'hFF;

  typedef enum logic [1:0] {
    CMD_SHADE   = 2'd0,
    CMD_PALETTE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_SHADE,
    OP_PALETTE,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    REG_ROT_COS = 3'd0,
    REG_ROT_SIN = 3'd1,
    REG_DRIFT   = 3'd2,
    REG_OUT_W   = 3'd3,
    REG_OUT_H   = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SH_MUL,
    ST_SH_SUM,
    ST_SH_RCP,
    ST_SH_FIX,
    ST_SH_PAL,
    ST_SH_WR,
    ST_RD_DIV,
    ST_RD_MAP,
    ST_RD_FETCH,
    ST_RD_BLEND,
    ST_RD_OUT
  } state_e;

  typedef struct packed {
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
    logic [15:0]        drift;
    logic [SIZE_W-1:0]  out_w;
    logic [SIZE_W-1:0]  out_h;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [18:0]        idx;
    logic signed [13:0] ca;
    logic signed [13:0] sa;
    logic [23:0]        color;
    logic [11:0]        ox;
    logic [11:0]        oy;
  } item_t;

  typedef logic [7:0] bright_tab_t [256];

  function automatic bright_tab_t bright_init();
    bright_tab_t tab;
    for (int k = 0; k < 256; k++) begin
      tab[k] = 8'((11475 + 55 * k) / 100);
    end
    return tab;
  endfunction

  localparam bright_tab_t BRIGHT_ROM = bright_init();

  // One 8-bit channel of a weighted mix, weight t of 256 on b.
  function automatic logic [7:0] blend_ch(logic [7:0] a, logic [7:0] b, logic [7:0] t);
    logic [8:0]  s;
    logic [16:0] acc;
    s   = 9'd256 - {1'b0, t};
    acc = 17'(a) * 17'(s) + 17'(b) * 17'(t);
    return acc[15:8];
  endfunction

  function automatic logic [23:0] blend_px(logic [23:0] a, logic [23:0] b, logic [7:0] t);
    return {blend_ch(a[23:16], b[23:16], t), blend_ch(a[15:8], b[15:8], t),
            blend_ch(a[7:0], b[7:0], t)};
  endfunction

  // Source position from a divider quotient: drop the half-pixel bias, clamp to the edge.
  function automatic logic [F_W-1:0] map_frac(logic [DIV_NUM_W-1:0] q,
                                              logic [DIV_NUM_W-1:0] fmax);
    logic [DIV_NUM_W-1:0] t;
    t = q - DIV_NUM_W'(32768);
    if (q < DIV_NUM_W'(32768)) begin
      return '0;
    end else if (t > fmax) begin
      return fmax[F_W-1:0];
    end
    return t[F_W-1:0];
  endfunction

endpackage

>>> rtl/core/psbu_front.sv
// Front end: accept transactions, sort them into operations, queue them.
`timescale 1ns / 1ps
module psbu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [18:0]          entry_index_i,
  input  logic signed [13:0]   cos_sum_i,
  input  logic signed [13:0]   sin_sum_i,
  input  logic [23:0]          palette_color_i,
  input  logic [11:0]          out_x_i,
  input  logic [11:0]          out_y_i,
  output logic                 item_valid_o,
  output psbu_pkg::item_t      item_o,
  input  logic                 item_pop_i
);

  psbu_pkg::item_t    mem_q [psbu_pkg::QDEPTH];
  logic [psbu_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [psbu_pkg::QAW:0]   cnt_q;
  psbu_pkg::item_t    item_d;
  logic               keep;
  logic               push, pop;

  // Drop out-of-range indexes and the unused command here.
  always_comb begin
    item_d.idx   = entry_index_i;
    item_d.ca    = cos_sum_i;
    item_d.sa    = sin_sum_i;
    item_d.color = palette_color_i;
    item_d.ox    = out_x_i;
    item_d.oy    = out_y_i;
    item_d.op    = psbu_pkg::OP_READ;
    keep         = 1'b0;
    case (command_i)
      psbu_pkg::CMD_SHADE: begin
        item_d.op = psbu_pkg::OP_SHADE;
        keep      = 32'(entry_index_i) < psbu_pkg::FRAME_PIXELS;
      end
      psbu_pkg::CMD_PALETTE: begin
        item_d.op = psbu_pkg::OP_PALETTE;
        keep      = 32'(entry_index_i) < psbu_pkg::PALETTE_SIZE;
      end
      psbu_pkg::CMD_READ: begin
        item_d.op = psbu_pkg::OP_READ;
        keep      = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o   = cnt_q != (psbu_pkg::QAW + 1)'(psbu_pkg::QDEPTH);
  assign push         = in_valid_i && in_ready_o && keep;
  assign item_valid_o = cnt_q != '0;
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_d;
  end

endmodule

>>> rtl/core/psbu_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module psbu_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [psbu_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [psbu_pkg::SIZE_W-1:0]       den_i,
  output logic                              busy_o,
  output logic [psbu_pkg::DIV_NUM_W-1:0]    quo_o
);

  logic                               busy_q;
  logic [psbu_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [psbu_pkg::DIV_NUM_W-1:0]     acc_q, acc_d;
  logic [psbu_pkg::SIZE_W-1:0]        rem_q, rem_d, den_q;
  logic [psbu_pkg::SIZE_W:0]          rem_sh, rem_sub;
  logic                               ge;

  always_comb begin
    rem_sh  = {rem_q, acc_q[psbu_pkg::DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    rem_d   = ge ? rem_sub[psbu_pkg::SIZE_W-1:0] : rem_sh[psbu_pkg::SIZE_W-1:0];
    acc_d   = {acc_q[psbu_pkg::DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= psbu_pkg::DIV_CNT_W'(psbu_pkg::DIV_NUM_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != psbu_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = acc_q;

endmodule

>>> rtl/core/psbu_back.sv
// Back end: shade pipeline, palette writes, scaled reads over the frame memory.
`timescale 1ns / 1ps
module psbu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psbu_pkg::cfg_t   cfg_i,
  input  logic             item_valid_i,
  input  psbu_pkg::item_t  item_i,
  output logic             item_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [23:0]      res_pixel_o
);

  localparam logic [psbu_pkg::DIV_NUM_W-1:0] FMAX_X =
    psbu_pkg::DIV_NUM_W'(psbu_pkg::SRC_WIDTH - 1) << 16;
  localparam logic [psbu_pkg::DIV_NUM_W-1:0] FMAX_Y =
    psbu_pkg::DIV_NUM_W'(psbu_pkg::SRC_HEIGHT - 1) << 16;

  psbu_pkg::state_e state_q, state_d;

  logic [23:0] frame_mem [psbu_pkg::FRAME_PIXELS];
  logic [23:0] pal_mem   [psbu_pkg::PALETTE_SIZE];

  // Shade path registers.
  logic [psbu_pkg::FRAME_AW-1:0] idx_q;
  logic signed [13:0]            ca_q, sa_q;
  logic signed [29:0]            p0_q, p1_q;
  logic [21:0]                   mag_q;
  logic                          neg_q;
  logic [15:0]                   qe_q;
  logic [11:0]                   v_q;
  logic [23:0]                   pal_rd_q;
  logic [7:0]                    g_q;

  // Read path registers.
  logic [psbu_pkg::XW-1:0]       x0_q, x1_q;
  logic [psbu_pkg::YW-1:0]       y0_q, y1_q;
  logic [7:0]                    wx_q, wy_q;
  logic [2:0]                    cnt_q;
  logic [23:0]                   px_q [4];
  logic [23:0]                   frame_rd_q;
  logic [23:0]                   top_q, bot_q;

  logic                          div_start, busy_x, busy_y;
  logic [psbu_pkg::DIV_NUM_W-1:0] num_x, num_y, quo_x, quo_y;
  logic [psbu_pkg::PROD_W-1:0]   prod_x, prod_y;
  logic [psbu_pkg::SIZE_W-1:0]   den_x, den_y;

  logic signed [30:0]            sum;
  logic signed [16:0]            wv;
  logic signed [22:0]            t45;
  logic [42:0]                   rcp;
  logic [21:0]                   rem;
  logic [15:0]                   qfix;
  logic signed [17:0]            vraw;
  logic [24:0]                   v7000;
  logic [16:0]                   pal_sum;
  logic [psbu_pkg::PAL_AW-1:0]   pidx;
  logic [23:0]                   shaded;
  logic [psbu_pkg::F_W-1:0]      fx, fy;
  logic [psbu_pkg::XW-1:0]       col;
  logic [psbu_pkg::YW-1:0]       row;
  logic [psbu_pkg::FRAME_AW-1:0] fetch_addr;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      psbu_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            psbu_pkg::OP_SHADE: state_d = psbu_pkg::ST_SH_MUL;
            psbu_pkg::OP_READ:  state_d = psbu_pkg::ST_RD_DIV;
            default:            state_d = psbu_pkg::ST_IDLE;
          endcase
        end
      end
      psbu_pkg::ST_SH_MUL:   state_d = psbu_pkg::ST_SH_SUM;
      psbu_pkg::ST_SH_SUM:   state_d = psbu_pkg::ST_SH_RCP;
      psbu_pkg::ST_SH_RCP:   state_d = psbu_pkg::ST_SH_FIX;
      psbu_pkg::ST_SH_FIX:   state_d = psbu_pkg::ST_SH_PAL;
      psbu_pkg::ST_SH_PAL:   state_d = psbu_pkg::ST_SH_WR;
      psbu_pkg::ST_SH_WR:    state_d = psbu_pkg::ST_IDLE;
      psbu_pkg::ST_RD_DIV:   if (!busy_x && !busy_y) state_d = psbu_pkg::ST_RD_MAP;
      psbu_pkg::ST_RD_MAP:   state_d = psbu_pkg::ST_RD_FETCH;
      psbu_pkg::ST_RD_FETCH: if (cnt_q == 3'd4) state_d = psbu_pkg::ST_RD_BLEND;
      psbu_pkg::ST_RD_BLEND: state_d = psbu_pkg::ST_RD_OUT;
      psbu_pkg::ST_RD_OUT:   if (res_ready_i) state_d = psbu_pkg::ST_IDLE;
      default:               state_d = psbu_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    item_pop_o  = (state_q == psbu_pkg::ST_IDLE) && item_valid_i;
    div_start   = item_pop_o && (item_i.op == psbu_pkg::OP_READ);
    res_valid_o = state_q == psbu_pkg::ST_RD_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= psbu_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Shade arithmetic.
  always_comb begin
    sum     = 31'(p0_q) + 31'(p1_q);
    wv      = 17'(sum >>> 14);
    t45     = 23'(wv) * 23'sd45;
    rcp     = 43'(mag_q) * 43'(psbu_pkg::RECIP_100);
    rem     = mag_q - 22'(qe_q) * 22'd100;
    qfix    = (rem >= 22'd100) ? qe_q + 16'd1 : qe_q;
    vraw    = neg_q ? 18'sd2048 - 18'(qfix) : 18'sd2048 + 18'(qfix);
    v7000   = 25'(v_q) * 25'd7000;
    pal_sum = 17'(cfg_i.drift) + 17'(v7000[24:12]);
    pidx    = pal_sum[psbu_pkg::PAL_AW-1:0];
    shaded  = {8'((16'(pal_rd_q[23:16]) * 16'(g_q)) >> 8),
               8'((16'(pal_rd_q[15:8]) * 16'(g_q)) >> 8),
               8'((16'(pal_rd_q[7:0]) * 16'(g_q)) >> 8)};
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      idx_q <= item_i.idx[psbu_pkg::FRAME_AW-1:0];
      ca_q  <= item_i.ca;
      sa_q  <= item_i.sa;
    end
    if (state_q == psbu_pkg::ST_SH_MUL) begin
      p0_q <= 30'(ca_q) * 30'(cfg_i.rot_cos);
      p1_q <= 30'(sa_q) * 30'(cfg_i.rot_sin);
    end
    if (state_q == psbu_pkg::ST_SH_SUM) begin
      neg_q <= t45 < 0;
      mag_q <= (t45 < 0) ? 22'(-t45) : 22'(t45);
    end
    if (state_q == psbu_pkg::ST_SH_RCP) begin
      qe_q <= 16'(rcp >> psbu_pkg::RECIP_SH);
    end
    if (state_q == psbu_pkg::ST_SH_FIX) begin
      if (vraw < 0)              v_q <= '0;
      else if (vraw > 18'sd4095) v_q <= 12'd4095;
      else                       v_q <= vraw[11:0];
    end
    if (state_q == psbu_pkg::ST_SH_PAL) begin
      g_q <= psbu_pkg::BRIGHT_ROM[v_q[11:4]];
    end
  end

  // Palette memory: written from the queue, read by the shade path.
  always_ff @(posedge clk_i) begin
    if (item_pop_o && (item_i.op == psbu_pkg::OP_PALETTE)) begin
      pal_mem[item_i.idx[psbu_pkg::PAL_AW-1:0]] <= item_i.color;
    end
    if (state_q == psbu_pkg::ST_SH_PAL) begin
      pal_rd_q <= pal_mem[pidx];
    end
  end

  // Source mapping dividers, one per axis.
  always_comb begin
    prod_x = psbu_pkg::PROD_W'({item_i.ox, 1'b1}) * psbu_pkg::PROD_W'(psbu_pkg::SRC_WIDTH);
    prod_y = psbu_pkg::PROD_W'({item_i.oy, 1'b1}) * psbu_pkg::PROD_W'(psbu_pkg::SRC_HEIGHT);
    num_x  = {prod_x, 15'd0};
    num_y  = {prod_y, 15'd0};
    den_x  = (cfg_i.out_w == '0) ? psbu_pkg::SIZE_W'(1) : cfg_i.out_w;
    den_y  = (cfg_i.out_h == '0) ? psbu_pkg::SIZE_W'(1) : cfg_i.out_h;
    fx     = psbu_pkg::map_frac(quo_x, FMAX_X);
    fy     = psbu_pkg::map_frac(quo_y, FMAX_Y);
    col    = cnt_q[0] ? x1_q : x0_q;
    row    = cnt_q[1] ? y1_q : y0_q;
    fetch_addr = psbu_pkg::FRAME_AW'(row) * psbu_pkg::FRAME_AW'(psbu_pkg::SRC_WIDTH)
               + psbu_pkg::FRAME_AW'(col);
  end

  psbu_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   (den_x),
    .busy_o  (busy_x),
    .quo_o   (quo_x)
  );

  psbu_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   (den_y),
    .busy_o  (busy_y),
    .quo_o   (quo_y)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == psbu_pkg::ST_RD_MAP) begin
      x0_q <= fx[16 +: psbu_pkg::XW];
      x1_q <= (fx[16 +: psbu_pkg::XW] == psbu_pkg::XW'(psbu_pkg::SRC_WIDTH - 1)) ?
              fx[16 +: psbu_pkg::XW] : fx[16 +: psbu_pkg::XW] + 1'b1;
      wx_q <= fx[15:8];
      y0_q <= fy[16 +: psbu_pkg::YW];
      y1_q <= (fy[16 +: psbu_pkg::YW] == psbu_pkg::YW'(psbu_pkg::SRC_HEIGHT - 1)) ?
              fy[16 +: psbu_pkg::YW] : fy[16 +: psbu_pkg::YW] + 1'b1;
      wy_q <= fy[15:8];
    end
    if (state_q == psbu_pkg::ST_RD_FETCH && cnt_q != 3'd0) begin
      px_q[cnt_q[1:0] - 2'd1] <= frame_rd_q;
    end
    if (state_q == psbu_pkg::ST_RD_BLEND) begin
      top_q <= psbu_pkg::blend_px(px_q[0], px_q[1], wx_q);
      bot_q <= psbu_pkg::blend_px(px_q[2], px_q[3], wx_q);
    end
  end

  // Fetch counter: issue four reads, capture each in the cycle after it issues.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == psbu_pkg::ST_RD_FETCH) begin
      cnt_q <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
    end
  end

  // Frame memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == psbu_pkg::ST_SH_WR) begin
      frame_mem[idx_q] <= shaded;
    end
    if (state_q == psbu_pkg::ST_RD_FETCH) begin
      frame_rd_q <= frame_mem[fetch_addr];
    end
  end

  assign res_pixel_o = psbu_pkg::blend_px(top_q, bot_q, wy_q);

endmodule

>>> rtl/core/palette_shade_bilinear_upscale.sv
// Top level of the palette shade upscaler: register port, front, back, result register.
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ---------------------------------
//  in        in         in_valid_i / in_ready_o       command, entry_index, cos_sum,
//                                                     sin_sum, palette_color, out_x, out_y
//  pixel     out        pixel_valid_o / pixel_ready_i pixel (ARGB8888)
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// The front accepts one transaction a cycle into a four-entry queue while it has room.
// The back handles one operation at a time; a scaled read waits on the two serial
// dividers (one quotient bit per cycle) that map the output position onto the source
// grid, and the four frame fetches share one read port.
// Reset clears control state and the config registers; the frame and palette memories keep
// whatever they hold and must be written before being read.
// A stalled pixel output holds the back in its last state; the queue keeps filling
// until full, then in_ready_o drops.
`timescale 1ns / 1ps
module palette_shade_bilinear_upscale (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // command stream
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [18:0]         entry_index_i,
  input  logic signed [13:0]  cos_sum_i,
  input  logic signed [13:0]  sin_sum_i,
  input  logic [23:0]         palette_color_i,
  input  logic [11:0]         out_x_i,
  input  logic [11:0]         out_y_i,
  // scaled pixels
  output logic                pixel_valid_o,
  input  logic                pixel_ready_i,
  output logic [31:0]         pixel_o
);

  psbu_pkg::cfg_t  cfg_q;
  psbu_pkg::item_t item;
  logic            item_valid, item_pop;
  logic            res_valid, res_ready;
  logic [23:0]     res_pixel;
  logic            pixel_valid_q;
  logic [31:0]     pixel_q;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  // Register port: zero wait states, write on the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_cos <= 16'sd16384;
      cfg_q.rot_sin <= 16'sd0;
      cfg_q.drift   <= 16'd0;
      cfg_q.out_w   <= psbu_pkg::SIZE_W'(640);
      cfg_q.out_h   <= psbu_pkg::SIZE_W'(480);
    end else if (cfg_wr) begin
      case (reg_idx)
        psbu_pkg::REG_ROT_COS: cfg_q.rot_cos <= pwdata[15:0];
        psbu_pkg::REG_ROT_SIN: cfg_q.rot_sin <= pwdata[15:0];
        psbu_pkg::REG_DRIFT:   cfg_q.drift   <= pwdata[15:0];
        psbu_pkg::REG_OUT_W:   cfg_q.out_w   <= pwdata[psbu_pkg::SIZE_W-1:0];
        psbu_pkg::REG_OUT_H:   cfg_q.out_h   <= pwdata[psbu_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      psbu_pkg::REG_ROT_COS: prdata = 32'({cfg_q.rot_cos});
      psbu_pkg::REG_ROT_SIN: prdata = 32'({cfg_q.rot_sin});
      psbu_pkg::REG_DRIFT:   prdata = 32'(cfg_q.drift);
      psbu_pkg::REG_OUT_W:   prdata = 32'(cfg_q.out_w);
      psbu_pkg::REG_OUT_H:   prdata = 32'(cfg_q.out_h);
      default:               prdata = '0;
    endcase
  end

  psbu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .cos_sum_i       (cos_sum_i),
    .sin_sum_i       (sin_sum_i),
    .palette_color_i (palette_color_i),
    .out_x_i         (out_x_i),
    .out_y_i         (out_y_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  psbu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_pixel_o  (res_pixel)
  );

  // Result register: load when empty or being drained, hold while stalled.
  assign res_ready = !pixel_valid_q || pixel_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_valid_q <= 1'b0;
    end else if (res_ready) begin
      pixel_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) pixel_q <= {psbu_pkg::ALPHA, res_pixel};
  end

  assign pixel_valid_o = pixel_valid_q;
  assign pixel_o       = pixel_q;

endmodule

>>> rtl/core/psbu_checker.sv
// Port checker for the palette shade upscaler, bound to the top level.
`timescale 1ns / 1ps
`include "palette_shade_bilinear_upscale_macros.svh"
module psbu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        pixel_valid_o,
  input logic        pixel_ready_i,
  input logic [31:0] pixel_o
);

  `PSBU_ASSERT(a_pixel_hold, pixel_valid_o && !pixel_ready_i |=> pixel_valid_o && $stable(pixel_o), "pixel changed while stalled")
  `PSBU_ASSERT(a_alpha, pixel_valid_o |-> pixel_o[31:24] == 8'hFF, "alpha not opaque")
  `PSBU_ASSERT_ALWAYS(a_pready, pready, "pready dropped")
  `PSBU_ASSERT_ALWAYS(a_reset_quiet, $past(!rst_ni) |-> !pixel_valid_o, "pixel valid right after reset")

endmodule

bind palette_shade_bilinear_upscale psbu_checker u_psbu_checker (.*);
